/* rtl/core/utf8_name_crc32c_hash_defines.svh */
// Assertion macros for the UTF-8 name hash block.
`ifndef UTF8_NAME_CRC32C_HASH_DEFINES_SVH
`define UTF8_NAME_CRC32C_HASH_DEFINES_SVH

// Same-cycle implication, checked on aclk outside reset.
`define UNH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define UNH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/unh_pkg.sv */
// Shared types, constants and functions for the UTF-8 name hash block.
`timescale 1ns / 1ps

package unh_pkg;

    localparam int unsigned HASH_W  = 22;
    localparam int unsigned CP_W    = 21;

    localparam logic [31:0]       CRC_POLY      = 32'h82F6_3B78;
    localparam logic [31:0]       CRC_SEED      = 32'hFFFF_FFFF;
    localparam logic [HASH_W-1:0] HASH_ALL_ONES = 22'h3F_FFFF;

    // Lead bytes with a restricted range for the first continuation byte
    localparam logic [7:0] LEAD_E0 = 8'hE0;
    localparam logic [7:0] LEAD_ED = 8'hED;
    localparam logic [7:0] LEAD_F0 = 8'hF0;
    localparam logic [7:0] LEAD_F4 = 8'hF4;

    typedef logic [31:0][31:0] crc_mat_t;

    typedef struct packed {
        logic            hash_en;   // a code point completes this cycle
        logic [CP_W-1:0] code_point;
        logic            bad;       // name is in error if it ends here
    } dec_status_t;

    // Column i is the CRC state after 32 shifts starting from bit i alone.
    function automatic crc_mat_t crc_matrix();
        crc_mat_t    m;
        logic [31:0] c;
        for (int i = 0; i < 32; i++) begin
            c = 32'h1 << i;
            for (int k = 0; k < 32; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            m[i] = c;
        end
        return m;
    endfunction

    // ASCII A-Z to a-z
    function automatic logic [7:0] fold_byte(logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b | 8'h20;
        end
        return r;
    endfunction

endpackage

/* rtl/core/unh_decode.sv */
// Strict UTF-8 decoder: sequence state registers and per-byte next-state logic.
`timescale 1ns / 1ps

module unh_decode (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [7:0]           name_byte,
    input  logic                 last_byte,
    output unh_pkg::dec_status_t status
);
    import unh_pkg::*;

    logic [CP_W-1:0] accum_reg, accum_next;
    logic [1:0]      pend_reg, pend_next;
    logic [7:0]      lead_reg, lead_next;
    logic            second_reg, second_next;
    logic            failed_reg, failed_next;
    logic            second_ok;
    logic [CP_W-1:0] accum_shift;

    always_comb begin
        priority if (lead_reg == LEAD_E0) begin
            second_ok = name_byte >= 8'hA0;
        end else if (lead_reg == LEAD_ED) begin
            second_ok = name_byte <= 8'h9F;
        end else if (lead_reg == LEAD_F0) begin
            second_ok = name_byte >= 8'h90;
        end else if (lead_reg == LEAD_F4) begin
            second_ok = name_byte <= 8'h8F;
        end else begin
            second_ok = 1'b1;
        end
    end

    assign accum_shift = {accum_reg[CP_W-7:0], name_byte[5:0]};

    always_comb begin
        accum_next         = accum_reg;
        pend_next          = pend_reg;
        lead_next          = lead_reg;
        second_next        = second_reg;
        failed_next        = failed_reg;
        status.hash_en     = 1'b0;
        status.code_point  = '0;
        if (!failed_reg) begin
            if (pend_reg == 2'd0) begin
                priority if (name_byte < 8'h80) begin
                    status.hash_en    = 1'b1;
                    status.code_point = {{(CP_W-8){1'b0}}, name_byte};
                end else if (name_byte >= 8'hC2 && name_byte <= 8'hDF) begin
                    accum_next  = {{(CP_W-5){1'b0}}, name_byte[4:0]};
                    pend_next   = 2'd1;
                    lead_next   = name_byte;
                    second_next = 1'b1;
                end else if (name_byte >= 8'hE0 && name_byte <= 8'hEF) begin
                    accum_next  = {{(CP_W-4){1'b0}}, name_byte[3:0]};
                    pend_next   = 2'd2;
                    lead_next   = name_byte;
                    second_next = 1'b1;
                end else if (name_byte >= 8'hF0 && name_byte <= 8'hF4) begin
                    accum_next  = {{(CP_W-3){1'b0}}, name_byte[2:0]};
                    pend_next   = 2'd3;
                    lead_next   = name_byte;
                    second_next = 1'b1;
                end else begin
                    failed_next = 1'b1;
                end
            end else if (name_byte[7:6] != 2'b10 || (second_reg && !second_ok)) begin
                failed_next = 1'b1;
            end else begin
                second_next = 1'b0;
                accum_next  = accum_shift;
                pend_next   = pend_reg - 2'd1;
                if (pend_reg == 2'd1) begin
                    status.hash_en    = 1'b1;
                    status.code_point = accum_shift;
                end
            end
        end
        // Truncated sequence at end of name counts as an error
        status.bad = failed_next || (pend_next != 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_byte)) begin
            accum_reg  <= '0;
            pend_reg   <= '0;
            lead_reg   <= '0;
            second_reg <= 1'b0;
            failed_reg <= 1'b0;
        end else if (step) begin
            accum_reg  <= accum_next;
            pend_reg   <= pend_next;
            lead_reg   <= lead_next;
            second_reg <= second_next;
            failed_reg <= failed_next;
        end
    end

endmodule

/* rtl/core/unh_crc.sv */
// Running CRC-32C over one code point per cycle while step is high, as four little-endian bytes.
`timescale 1ns / 1ps

module unh_crc (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic                 last_byte,
    input  logic                 fold_en,
    input  unh_pkg::dec_status_t status,
    output logic [31:0]          crc_out
);
    import unh_pkg::*;

    localparam crc_mat_t CRC_MAT = crc_matrix();

    logic [31:0] crc_reg;
    logic [31:0] word;
    logic [31:0] crc_in;
    logic [31:0] crc_adv;

    always_comb begin
        word = {{(32-CP_W){1'b0}}, status.code_point};
        if (fold_en) begin
            for (int i = 0; i < 4; i++) begin
                word[8*i +: 8] = fold_byte(word[8*i +: 8]);
            end
        end
    end

    // Reflected CRC: xor the whole word in, then 32 shifts as one XOR matrix
    assign crc_in = crc_reg ^ word;

    always_comb begin
        crc_adv = '0;
        for (int i = 0; i < 32; i++) begin
            if (crc_in[i]) begin
                crc_adv = crc_adv ^ CRC_MAT[i];
            end
        end
    end

    assign crc_out = status.hash_en ? crc_adv : crc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_byte)) begin
            crc_reg <= CRC_SEED;
        end else if (step) begin
            crc_reg <= crc_out;
        end
    end

endmodule

/* rtl/core/utf8_name_crc32c_hash.sv */
// Path: a name's last byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle unless a last byte stalls; input register and result register in line.
// A byte is taken while a result waits, stalling only on a last byte.
// Reset (aresetn low, synchronous) clears case_insensitive, the decoder
// state, the CRC to all ones and both valid flags.
`timescale 1ns / 1ps

`include "utf8_name_crc32c_hash_defines.svh"

module utf8_name_crc32c_hash (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_name_byte,
    input  logic                       s_last_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [unh_pkg::HASH_W-1:0] m_name_hash,
    output logic                       m_bad_encoding
);
    import unh_pkg::*;

    logic              case_ins_reg;
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              out_valid_reg, out_valid_next;
    logic [HASH_W-1:0] out_hash_reg;
    logic              out_bad_reg;
    logic              consume;
    logic              step;
    dec_status_t       status;
    logic [31:0]       crc_out;

    // A last byte needs room in the result register
    assign consume = !in_last_reg || !out_valid_reg || m_ready;
    assign step    = in_valid_reg && consume;
    assign s_ready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            case_ins_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case_ins_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_name_byte;
            in_last_reg <= s_last_byte;
        end
    end

    unh_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .name_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .status    (status)
    );

    unh_crc u_crc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .last_byte (in_last_reg),
        .fold_en   (case_ins_reg),
        .status    (status),
        .crc_out   (crc_out)
    );

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if (step && in_last_reg) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && in_last_reg) begin
            out_hash_reg <= status.bad ? HASH_ALL_ONES : crc_out[HASH_W-1:0];
            out_bad_reg  <= status.bad;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_name_hash    = out_hash_reg;
    assign m_bad_encoding = out_bad_reg;

    `UNH_ASSERT_NOW(a_bad_all_ones, m_valid && m_bad_encoding, m_name_hash == HASH_ALL_ONES, "error result must carry an all-ones hash")
    `UNH_ASSERT_NOW(a_last_stall, in_valid_reg && in_last_reg && m_valid && !m_ready, !s_ready && !step, "last byte advanced into a full result register")
    `UNH_ASSERT_NEXT(a_result_follows, step && in_last_reg, m_valid, "last byte transfer produced no result")

endmodule
